// File: rtl/core/lobfe_pkg.sv
// lobfe_pkg: shared constants and types of the order book fill engine
// no dependencies
`default_nettype none
package lobfe_pkg;
  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_W = $clog2(ORDER_SLOTS);

  localparam logic [2:0] OP_TRADE  = 3'd0;
  localparam logic [2:0] OP_ASK    = 3'd1;
  localparam logic [2:0] OP_BID    = 3'd2;
  localparam logic [2:0] OP_PLACE  = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;

  localparam logic [2:0] K_FILL    = 3'd0;
  localparam logic [2:0] K_ACCEPT  = 3'd1;
  localparam logic [2:0] K_BADQTY  = 3'd2;
  localparam logic [2:0] K_BADPX   = 3'd3;
  localparam logic [2:0] K_FULL    = 3'd4;
  localparam logic [2:0] K_CANCEL  = 3'd5;
  localparam logic [2:0] K_CANREJ  = 3'd6;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] order_id;
    logic        is_buy;
    logic signed [31:0] price;
    logic [31:0] quantity;
    logic        trade_hit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] result_id;
    logic [31:0] fill_quantity;
    logic [30:0] fill_price;
    logic        still_open;
    logic        last;
  } out_item_t;

  // one resting order as held in the slot memory
  typedef struct packed {
    logic [31:0] id;
    logic        buy;
    logic [30:0] price;
    logic [31:0] leaves;
    logic [31:0] age;
  } slot_t;
endpackage
`default_nettype wire

// File: rtl/core/lobfe_if.sv
// lobfe_if: valid/ready channel carrying one beat of a given payload type
// depends on lobfe_pkg for payload types
`default_nettype none
interface lobfe_in_if;
  logic valid;
  logic ready;
  lobfe_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lobfe_out_if;
  logic valid;
  logic ready;
  lobfe_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/limit_order_book_fill_engine.sv
// limit_order_book_fill_engine: resting order book with quote-driven fills
// depends on lobfe_pkg and the channel interfaces in lobfe_if
`default_nettype none
// Resting order book for one instrument, up to ORDER_SLOTS orders held in a
// slot memory with a registered read. Each input beat is handled by a
// sequencer that walks the slot memory one entry a cycle. A fill search
// sweeps all slots to find the best order, then reads the best slot back
// and writes the fill; the search runs again after each fill, plus one more
// sweep when a trade tick goes on to the sell side. A place first picks a
// free slot; a cancel runs its id sweep in place of the fill search. Output
// stalls hold the sequencer while a result waits to be shown.
// Valid bits sit in flip-flops. Results wait in an output register, one beat
// at a time.
module limit_order_book_fill_engine (
  input  wire clk_i,
  input  wire rst_ni,
  lobfe_in_if.sink    in_ch,
  lobfe_out_if.source out_ch
);
  import lobfe_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1; // sweep for free slot or cancel id
  localparam logic [2:0] S_SRCH  = 3'd2; // sweep for best fill candidate
  localparam logic [2:0] S_FILL  = 3'd3; // apply fill to best slot
  localparam logic [2:0] S_EMIT  = 3'd4; // not entered; output waits happen in S_FILL and S_DONE
  localparam logic [2:0] S_DONE  = 3'd5; // item finished, flag last

  localparam logic [SLOT_W:0] NSLOT = (SLOT_W+1)'(ORDER_SLOTS);

  slot_t mem_q [ORDER_SLOTS];
  slot_t rd_q;
  logic [ORDER_SLOTS-1:0] valid_q, valid_d;

  logic [2:0] st_q, st_d;
  in_item_t it_q, it_d;
  logic [SLOT_W:0] ptr_q, ptr_d;      // read address of the sweep
  logic            rv_q, rv_d;        // read data in rd_q valid
  logic [SLOT_W-1:0] ridx_q, ridx_d;  // slot index of rd_q
  logic            side_q, side_d;    // side being filled, 1 buy
  logic signed [32:0] px_q, px_d;
  logic [31:0]     qty_q, qty_d;
  logic            two_q, two_d;      // trade tick: sells after buys
  logic            found_q, found_d;
  logic [SLOT_W-1:0] best_q, best_d;
  logic [30:0]     bpx_q, bpx_d;
  logic [31:0]     bage_q, bage_d;    // age measure of best
  logic            pend_q, pend_d;    // a result is held in hold_q not yet shown
  out_item_t       hold_q, hold_d;    // result not yet known to be last

  logic [31:0] arr_q, arr_d;
  logic [30:0] askp_q, askp_d, bidp_q, bidp_d;
  logic [31:0] asks_q, asks_d, bids_q, bids_d;

  logic      ov_q, ov_d;
  out_item_t od_q, od_d;

  logic            wr_en;
  logic [SLOT_W-1:0] wr_a;
  slot_t           wr_data;

  // slot memory: one write and one read port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_a] <= wr_data;
    rd_q <= mem_q[ptr_q[SLOT_W-1:0] < SLOT_W'(ORDER_SLOTS-1) ?
                  ptr_q[SLOT_W-1:0] : SLOT_W'(ORDER_SLOTS-1)];
  end

  logic out_free;
  assign out_free = !ov_q || out_ch.ready;
  assign in_ch.ready = (st_q == S_IDLE);
  assign out_ch.valid = ov_q;
  assign out_ch.data = od_q;

  function automatic out_item_t mk(logic [2:0] k, logic [31:0] id, logic [31:0] q,
                                   logic [30:0] p, logic o);
    out_item_t r;
    r.kind = k; r.result_id = id; r.fill_quantity = q;
    r.fill_price = p; r.still_open = o; r.last = 1'b0;
    return r;
  endfunction

  // sequencer
  always_comb begin
    logic [31:0] age, f, lv;
    logic elig, better;
    st_d = st_q; it_d = it_q; ptr_d = ptr_q; rv_d = 1'b0; ridx_d = ridx_q;
    side_d = side_q; px_d = px_q; qty_d = qty_q; two_d = two_q;
    found_d = found_q; best_d = best_q; bpx_d = bpx_q; bage_d = bage_q;
    pend_d = pend_q; hold_d = hold_q;
    arr_d = arr_q; askp_d = askp_q; bidp_d = bidp_q; asks_d = asks_q; bids_d = bids_q;
    valid_d = valid_q; ov_d = ov_q; od_d = od_q;
    wr_en = 1'b0; wr_a = best_q; wr_data = rd_q;
    age = arr_q - rd_q.age; f = '0; lv = '0; elig = 1'b0; better = 1'b0;
    if (ov_q && out_ch.ready) ov_d = 1'b0;

    case (st_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          it_d = in_ch.data;
          px_d = {in_ch.data.price[31], in_ch.data.price};
          qty_d = in_ch.data.quantity;
          ptr_d = '0; found_d = 1'b0; two_d = 1'b0; pend_d = 1'b0;
          st_d = S_DONE;
          case (in_ch.data.op)
            OP_TRADE: begin
              if (in_ch.data.trade_hit && !in_ch.data.price[31] &&
                  in_ch.data.price != 0 && in_ch.data.quantity != 0) begin
                side_d = 1'b1; two_d = 1'b1; st_d = S_SRCH;
              end
            end
            OP_ASK: begin
              if (!in_ch.data.price[31]) begin
                askp_d = in_ch.data.price[30:0]; asks_d = in_ch.data.quantity;
                side_d = 1'b1; st_d = S_SRCH;
              end
            end
            OP_BID: begin
              if (!in_ch.data.price[31]) begin
                bidp_d = in_ch.data.price[30:0]; bids_d = in_ch.data.quantity;
                side_d = 1'b0; st_d = S_SRCH;
              end
            end
            OP_PLACE: begin
              pend_d = 1'b1;
              if (in_ch.data.quantity == 0)
                hold_d = mk(K_BADQTY, in_ch.data.order_id, '0, '0, 1'b0);
              else if (in_ch.data.price[31])
                hold_d = mk(K_BADPX, in_ch.data.order_id, '0, '0, 1'b0);
              else begin
                pend_d = 1'b0; st_d = S_FIND;
              end
            end
            OP_CANCEL: st_d = S_FIND;
            default: st_d = S_IDLE;
          endcase
          if (st_d == S_SRCH) begin
            ptr_d = '0; rv_d = 1'b0;
          end
        end
      end

      // lowest free slot, or lowest valid slot with matching id
      S_FIND: begin
        if (it_q.op == OP_PLACE) begin
          pend_d = 1'b1;
          best_d = '0; found_d = 1'b0;
          for (int i = ORDER_SLOTS-1; i >= 0; i--)
            if (!valid_q[i]) begin found_d = 1'b1; best_d = SLOT_W'(i); end
          if (!found_d) begin
            hold_d = mk(K_FULL, it_q.order_id, '0, '0, 1'b0); st_d = S_DONE;
          end else begin
            wr_en = 1'b1; wr_a = best_d;
            wr_data.id = it_q.order_id; wr_data.buy = it_q.is_buy;
            wr_data.price = it_q.price[30:0]; wr_data.leaves = it_q.quantity;
            wr_data.age = arr_q;
            valid_d[best_d] = 1'b1; arr_d = arr_q + 32'd1;
            hold_d = mk(K_ACCEPT, it_q.order_id, '0, '0, 1'b0);
            side_d = it_q.is_buy;
            px_d = it_q.is_buy ? {2'b0, askp_q} : {2'b0, bidp_q};
            qty_d = it_q.is_buy ? asks_q : bids_q;
            ptr_d = '0; found_d = 1'b0;
            st_d = ((it_q.is_buy ? askp_q : bidp_q) != 0) ? S_SRCH : S_DONE;
          end
        end else begin
          // cancel: sweep the memory for the id
          if (rv_q && valid_q[ridx_q] && rd_q.id == it_q.order_id && !found_d) begin
            found_d = 1'b1; valid_d[ridx_q] = 1'b0;
          end
          if (ptr_q < NSLOT) begin
            ridx_d = ptr_q[SLOT_W-1:0]; rv_d = 1'b1; ptr_d = ptr_q + 1'b1;
          end else if (!rv_q) begin
            pend_d = 1'b1;
            hold_d = mk(found_q ? K_CANCEL : K_CANREJ, it_q.order_id, '0, '0, 1'b0);
            st_d = S_DONE;
          end
          if (found_d && !found_q) begin
            pend_d = 1'b1;
            hold_d = mk(K_CANCEL, it_q.order_id, '0, '0, 1'b0);
            st_d = S_DONE;
          end
        end
      end

      // priority sweep: one slot compared a cycle
      S_SRCH: begin
        if (qty_q == 0) begin
          st_d = S_DONE;
        end else begin
          if (rv_q) begin
            elig = valid_q[ridx_q] && (rd_q.buy == side_q) &&
                   (side_q ? (px_q <= $signed({2'b0, rd_q.price}))
                           : (px_q >= $signed({2'b0, rd_q.price})));
            if (side_q)
              better = (rd_q.price > bpx_q) || (rd_q.price == bpx_q && age < bage_q);
            else
              better = (rd_q.price < bpx_q) || (rd_q.price == bpx_q && age > bage_q);
            if (elig && (!found_q || better)) begin
              found_d = 1'b1; best_d = ridx_q; bpx_d = rd_q.price; bage_d = age;
            end
          end
          if (ptr_q < NSLOT) begin
            ridx_d = ptr_q[SLOT_W-1:0]; rv_d = 1'b1; ptr_d = ptr_q + 1'b1;
          end else if (!rv_q) begin
            if (found_q) begin
              ptr_d = {1'b0, best_q}; st_d = S_FILL;
            end else if (two_q && side_q) begin
              side_d = 1'b0; found_d = 1'b0; ptr_d = '0;
            end else begin
              st_d = S_DONE;
            end
          end
        end
      end

      // best slot read back; rd_q holds it once rv_q is set
      S_FILL: begin
        if (!rv_q) begin
          rv_d = 1'b1; ridx_d = best_q;
        end else if (!pend_q || out_free) begin
          f = (qty_q < rd_q.leaves) ? qty_q : rd_q.leaves;
          lv = rd_q.leaves - f;
          qty_d = qty_q - f;
          wr_en = 1'b1; wr_a = best_q; wr_data = rd_q; wr_data.leaves = lv;
          if (lv == 0) valid_d[best_q] = 1'b0;
          if (pend_q) begin
            ov_d = 1'b1; od_d = hold_q;
          end
          pend_d = 1'b1;
          hold_d = mk(K_FILL, rd_q.id, f, rd_q.price, lv != 0);
          found_d = 1'b0; ptr_d = '0; st_d = S_SRCH;
        end else begin
          rv_d = 1'b1;
        end
      end

      // flush the held result marked last
      S_DONE: begin
        if (!pend_q) st_d = S_IDLE;
        else if (out_free) begin
          ov_d = 1'b1; od_d = hold_q; od_d.last = 1'b1; pend_d = 1'b0; st_d = S_IDLE;
        end
      end

      default: st_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; valid_q <= '0; ov_q <= 1'b0; pend_q <= 1'b0; rv_q <= 1'b0;
      ptr_q <= '0; found_q <= 1'b0; arr_q <= '0;
      askp_q <= '0; bidp_q <= '0; asks_q <= '0; bids_q <= '0;
    end else begin
      st_q <= st_d; valid_q <= valid_d; ov_q <= ov_d; pend_q <= pend_d; rv_q <= rv_d;
      ptr_q <= ptr_d; found_q <= found_d; arr_q <= arr_d;
      askp_q <= askp_d; bidp_q <= bidp_d; asks_q <= asks_d; bids_q <= bids_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    it_q <= it_d; ridx_q <= ridx_d; side_q <= side_d; px_q <= px_d; qty_q <= qty_d;
    two_q <= two_d; best_q <= best_d; bpx_q <= bpx_d; bage_q <= bage_d;
    hold_q <= hold_d; od_q <= od_d;
  end

  // a shown beat holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ch.ready |=> ov_q && $stable(od_q))
    else $error("output beat changed while stalled");
  // no new item while a result is still held
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> !pend_q)
    else $error("held result left behind");
  // a fill write-back never targets an empty slot
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_FILL && rv_q && (!pend_q || out_free) |-> valid_q[best_q])
    else $error("fill on empty slot");
endmodule
`default_nettype wire
